// ===== sv/vsr_pkg.sv =====
// Shared command codes and control structs for the voxel shape rasterizer.
package vsr_pkg;

   typedef enum logic [3:0] {
      KIND_PUT_VOXEL  = 4'd0,
      KIND_CUT_VOXEL  = 4'd1,
      KIND_PUT_BOX    = 4'd2,
      KIND_CUT_BOX    = 4'd3,
      KIND_PUT_ELLIP  = 4'd4,
      KIND_CUT_ELLIP  = 4'd5,
      KIND_PUT_SPHERE = 4'd6,
      KIND_CUT_SPHERE = 4'd7,
      KIND_READ       = 4'd8
   } kind_type;

   localparam logic [1:0] CSR_RED   = 2'd0;
   localparam logic [1:0] CSR_GREEN = 2'd1;
   localparam logic [1:0] CSR_BLUE  = 2'd2;
   localparam logic [1:0] CSR_ALPHA = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture command
      logic clr_start;  // reset clearing sweep coordinates
      logic clr_step;   // write zero at sweep coordinate, advance
      logic sw_start;   // reset shape sweep coordinates
      logic sw_step;    // advance sweep pipeline one voxel
      logic pt_write;   // single voxel write
      logic rd_issue;   // memory read for read command
      logic rsp_fire;   // drive result strobe
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_done;
      logic sw_done;    // last coordinate issued
      logic pipe_empty; // no sweep writes in flight
   } sts_type;

endpackage

// ===== sv/vsr_datapath.sv =====
// Datapath: command registers, coordinate sweep, inside test pipeline, voxel memory.
module vsr_datapath import vsr_pkg::*; #(
   parameter int GRID_X = 64,
   parameter int GRID_Y = 64,
   parameter int GRID_Z = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output sts_type    sts,
   input  logic [3:0] kind,
   input  logic [7:0] pos_x, pos_y, pos_z,
   input  logic [7:0] end_x, end_y, end_z,
   input  logic [6:0] radius_x, radius_y, radius_z,
   input  logic [31:0] color,
   output logic       out_on,
   output logic [31:0] out_rgba
);
   localparam int XW = (GRID_X > 1) ? $clog2(GRID_X) : 1;
   localparam int YW = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
   localparam int ZW = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
   localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
   localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;

   logic [3:0] kind_ff;
   logic signed [8:0] px_ff, py_ff, pz_ff;
   logic [XW:0] x0_ff, x1_ff;
   logic [YW:0] y0_ff, y1_ff;
   logic [ZW:0] z0_ff, z1_ff;
   logic [6:0] rx_ff, ry_ff, rz_ff;
   // precomputed weights: a = r^2 (14b), w = a*a (28b), lim = a*a*a (42b)
   logic [13:0] ax_ff, ay_ff, az_ff;
   logic [27:0] wx_ff, wy_ff, wz_ff, axy_ff;
   logic [41:0] lim_ff;
   logic [2:0] pre_ff;

   logic [XW-1:0] sx_ff; logic [YW-1:0] sy_ff; logic [ZW-1:0] sz_ff;
   logic sw_done_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= kind;
         px_ff <= {pos_x[7], pos_x}; py_ff <= {pos_y[7], pos_y};
         pz_ff <= {pos_z[7], pos_z};
         rx_ff <= radius_x; ry_ff <= radius_y; rz_ff <= radius_z;
         x0_ff <= pos_x[7] ? '0 : ((pos_x > GRID_X) ? (XW+1)'(GRID_X) : (XW+1)'(pos_x));
         y0_ff <= pos_y[7] ? '0 : ((pos_y > GRID_Y) ? (YW+1)'(GRID_Y) : (YW+1)'(pos_y));
         z0_ff <= pos_z[7] ? '0 : ((pos_z > GRID_Z) ? (ZW+1)'(GRID_Z) : (ZW+1)'(pos_z));
         x1_ff <= end_x[7] ? '0 : ((end_x > GRID_X) ? (XW+1)'(GRID_X) : (XW+1)'(end_x));
         y1_ff <= end_y[7] ? '0 : ((end_y > GRID_Y) ? (YW+1)'(GRID_Y) : (YW+1)'(end_y));
         z1_ff <= end_z[7] ? '0 : ((end_z > GRID_Z) ? (ZW+1)'(GRID_Z) : (ZW+1)'(end_z));
      end
   end

   // weight precompute after load, in steps: squares, pair products, then lim
   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff <= '0;
      end else if (cmd.load) begin
         pre_ff <= 3'd1;
      end else if (pre_ff != 3'd0 && pre_ff != 3'd4) begin
         pre_ff <= pre_ff + 3'd1;
      end
   end
   always_ff @(posedge clock) begin
      if (pre_ff == 3'd1) begin
         ax_ff <= rx_ff * rx_ff; ay_ff <= ry_ff * ry_ff; az_ff <= rz_ff * rz_ff;
      end
      if (pre_ff == 3'd2) begin
         wx_ff <= ay_ff * az_ff; wy_ff <= ax_ff * az_ff; wz_ff <= ax_ff * ay_ff;
         axy_ff <= ax_ff * ay_ff;
      end
      if (pre_ff == 3'd3) begin
         lim_ff <= axy_ff * az_ff;
      end
   end

   logic is_box, is_ell, is_sph, is_fill;
   assign is_box  = (kind_ff == KIND_PUT_BOX) || (kind_ff == KIND_CUT_BOX);
   assign is_ell  = (kind_ff == KIND_PUT_ELLIP) || (kind_ff == KIND_CUT_ELLIP);
   assign is_sph  = (kind_ff == KIND_PUT_SPHERE) || (kind_ff == KIND_CUT_SPHERE);
   assign is_fill = !kind_ff[0];

   logic box_empty, shape_zero;
   assign box_empty = (x0_ff >= x1_ff) || (y0_ff >= y1_ff) || (z0_ff >= z1_ff);
   assign shape_zero = is_sph ? (rx_ff == '0)
                              : ((rx_ff == '0) || (ry_ff == '0) || (rz_ff == '0));

   logic [XW-1:0] xs, xe_m1; logic [YW-1:0] ys, ye_m1; logic [ZW-1:0] zs, ze_m1;
   logic sweep_skip;
   always_comb begin
      if (is_box) begin
         xs = x0_ff[XW-1:0]; ys = y0_ff[YW-1:0]; zs = z0_ff[ZW-1:0];
         xe_m1 = XW'(x1_ff - 1'b1); ye_m1 = YW'(y1_ff - 1'b1); ze_m1 = ZW'(z1_ff - 1'b1);
         sweep_skip = box_empty;
      end else begin
         xs = '0; ys = '0; zs = '0;
         xe_m1 = XW'(GRID_X - 1); ye_m1 = YW'(GRID_Y - 1); ze_m1 = ZW'(GRID_Z - 1);
         sweep_skip = shape_zero || !(is_ell || is_sph);
      end
   end

   // sweep counter, z fastest
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_done_ff <= 1'b0;
      end else if (cmd.sw_start) begin
         sx_ff <= xs; sy_ff <= ys; sz_ff <= zs;
         sw_done_ff <= sweep_skip;
      end else if (cmd.clr_start) begin
         sx_ff <= '0; sy_ff <= '0; sz_ff <= '0;
         sw_done_ff <= 1'b0;
      end else if (cmd.sw_step || cmd.clr_step) begin
         if (sz_ff != ze_m1 && !cmd.clr_step || cmd.clr_step && sz_ff != ZW'(GRID_Z - 1)) begin
            sz_ff <= sz_ff + 1'b1;
         end else begin
            sz_ff <= cmd.clr_step ? '0 : zs;
            if (sy_ff != ye_m1 && !cmd.clr_step || cmd.clr_step && sy_ff != YW'(GRID_Y - 1))
            begin
               sy_ff <= sy_ff + 1'b1;
            end else begin
               sy_ff <= cmd.clr_step ? '0 : ys;
               if (sx_ff != xe_m1 && !cmd.clr_step || cmd.clr_step && sx_ff != XW'(GRID_X - 1))
               begin
                  sx_ff <= sx_ff + 1'b1;
               end else begin
                  sw_done_ff <= 1'b1;
               end
            end
         end
      end
   end

   function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x,
                                             input logic [YW-1:0] y,
                                             input logic [ZW-1:0] z);
      addr_of = AW'((32'(x) * GRID_Y + 32'(y)) * GRID_Z + 32'(z));
   endfunction

   // sweep pipeline: s1 |d| ; s2 d^2 ; s3 d^2*w ; s4 sum, compare ; s5 write
   logic [3:0] v_ff;
   logic [AW-1:0] a1_ff, a2_ff, a3_ff, a4_ff;
   logic [7:0] dx1_ff, dy1_ff, dz1_ff;
   logic [15:0] qx2_ff, qy2_ff, qz2_ff;
   logic [43:0] tx3_ff, ty3_ff, tz3_ff;
   logic in4_ff;

   logic signed [9:0] ddx, ddy, ddz;
   assign ddx = $signed({2'b00, 8'(sx_ff)}) - 10'(px_ff);
   assign ddy = $signed({2'b00, 8'(sy_ff)}) - 10'(py_ff);
   assign ddz = $signed({2'b00, 8'(sz_ff)}) - 10'(pz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[2:0], cmd.sw_step};
      end
   end

   always_ff @(posedge clock) begin
      a1_ff <= addr_of(sx_ff, sy_ff, sz_ff);
      dx1_ff <= 8'(ddx[9] ? -ddx : ddx);
      dy1_ff <= 8'(ddy[9] ? -ddy : ddy);
      dz1_ff <= 8'(ddz[9] ? -ddz : ddz);
      a2_ff <= a1_ff;
      qx2_ff <= dx1_ff * dx1_ff; qy2_ff <= dy1_ff * dy1_ff; qz2_ff <= dz1_ff * dz1_ff;
      a3_ff <= a2_ff;
      if (is_ell) begin
         tx3_ff <= qx2_ff * wx_ff; ty3_ff <= qy2_ff * wy_ff; tz3_ff <= qz2_ff * wz_ff;
      end else begin
         tx3_ff <= 44'(qx2_ff); ty3_ff <= 44'(qy2_ff); tz3_ff <= 44'(qz2_ff);
      end
      a4_ff <= a3_ff;
      if (is_box) begin
         in4_ff <= 1'b1;
      end else if (is_ell) begin
         in4_ff <= (46'(tx3_ff) + 46'(ty3_ff) + 46'(tz3_ff)) < 46'(lim_ff);
      end else begin
         in4_ff <= (46'(tx3_ff) + 46'(ty3_ff) + 46'(tz3_ff)) < 46'(ax_ff);
      end
   end

   assign sts.clr_done   = sw_done_ff;
   assign sts.sw_done    = sw_done_ff;
   assign sts.pipe_empty = (v_ff == '0);

   // single voxel address
   logic pt_in;
   logic [AW-1:0] pt_addr;
   assign pt_in = !px_ff[8] && (px_ff < GRID_X) && !py_ff[8] && (py_ff < GRID_Y)
                  && !pz_ff[8] && (pz_ff < GRID_Z);
   assign pt_addr = addr_of(XW'(px_ff), YW'(py_ff), ZW'(pz_ff));

   // memory: on flag and colour in separate arrays; cut writes on=0 and keeps colour via its own write enable
   logic        mem_on [CELLS];
   logic [31:0] mem_rgba [CELLS];
   logic        we_on, we_rgba, wd_on;
   logic [AW-1:0] waddr;
   always_comb begin
      we_on = 1'b0; we_rgba = 1'b0; wd_on = 1'b0; waddr = a4_ff;
      if (cmd.clr_step) begin
         waddr = addr_of(sx_ff, sy_ff, sz_ff);
         we_on = 1'b1; we_rgba = 1'b1; wd_on = 1'b0;
      end else if (cmd.pt_write) begin
         waddr = pt_addr;
         we_on = pt_in; we_rgba = pt_in && is_fill; wd_on = is_fill;
      end else if (v_ff[3]) begin
         we_on = in4_ff; we_rgba = in4_ff && is_fill; wd_on = is_fill;
      end
   end
   always_ff @(posedge clock) begin
      if (we_on) begin
         mem_on[waddr] <= wd_on;
      end
      if (we_rgba) begin
         mem_rgba[waddr] <= cmd.clr_step ? '0 : color;
      end
   end

   logic rd_on_ff; logic [31:0] rd_rgba_ff; logic rd_ok_ff;
   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         rd_on_ff   <= mem_on[pt_addr];
         rd_rgba_ff <= mem_rgba[pt_addr];
         rd_ok_ff   <= pt_in && (kind_ff == KIND_READ);
      end
   end
   assign out_on   = rd_ok_ff & rd_on_ff;
   assign out_rgba = rd_ok_ff ? rd_rgba_ff : '0;
endmodule

// ===== sv/vsr_control.sv =====
// Controller: reset clearing pass, command sequencing and result strobe.
module vsr_control import vsr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic [3:0] kind,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy
);
   typedef enum logic [2:0] {
      S_CLR_INIT, S_CLR, S_IDLE, S_PREP, S_SWEEP, S_DRAIN, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] wait_ff, wait_in;
   logic [3:0] kind_ff, kind_in;

   always_comb begin
      state_in = state_ff; wait_in = wait_ff; kind_in = kind_ff;
      cmd = '0;
      case (state_ff)
         S_CLR_INIT: begin
            cmd.clr_start = 1'b1;
            state_in = S_CLR;
         end
         S_CLR: begin
            if (sts.clr_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.clr_step = 1'b1;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               kind_in = kind;
               wait_in = '0;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            // let weight multiplies settle
            wait_in = wait_ff + 3'd1;
            if (wait_ff == 3'd4) begin
               if (kind_ff inside {KIND_PUT_VOXEL, KIND_CUT_VOXEL}) begin
                  // read beside the write so the result fields come back zero
                  cmd.pt_write = 1'b1;
                  cmd.rd_issue = 1'b1;
                  state_in = S_RESP;
               end else if (kind_ff inside {[KIND_PUT_BOX : KIND_CUT_SPHERE]}) begin
                  cmd.sw_start = 1'b1;
                  state_in = S_SWEEP;
               end else begin
                  cmd.rd_issue = 1'b1;
                  state_in = S_RESP;
               end
            end
         end
         S_SWEEP: begin
            if (sts.sw_done) begin
               state_in = S_DRAIN;
            end else begin
               cmd.sw_step = 1'b1;
            end
         end
         S_DRAIN: begin
            if (sts.pipe_empty) begin
               cmd.rd_issue = 1'b1;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            cmd.rsp_fire = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR_INIT;
         wait_ff  <= '0;
         kind_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         kind_ff  <= kind_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
endmodule

// ===== sv/voxel_shape_rasterizer.sv =====
// Top level of the voxel shape rasterizer.
// After reset the block clears every voxel, one per cycle, holding busy high. A voxel
// put/cut, a read or an unknown code needs no sweep; a box sweeps its volume clamped to
// the grid (none when the box is empty); an ellipsoid or sphere sweeps the whole
// GRID_X*GRID_Y*GRID_Z grid (none when a radius it uses is zero), paced by the single
// memory write port that takes one voxel per cycle. Every command yields exactly one
// result beat on rsp_valid, one cycle wide; the receiver cannot stall it. Only read
// returns nonzero fields. Write the colour registers only while busy is low.
module voxel_shape_rasterizer import vsr_pkg::*; #(
   parameter int GRID_X = 64,
   parameter int GRID_Y = 64,
   parameter int GRID_Z = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [3:0] req_kind,
   input  logic [7:0] req_pos_x,
   input  logic [7:0] req_pos_y,
   input  logic [7:0] req_pos_z,
   input  logic [7:0] req_end_x,
   input  logic [7:0] req_end_y,
   input  logic [7:0] req_end_z,
   input  logic [6:0] req_radius_x,
   input  logic [6:0] req_radius_y,
   input  logic [6:0] req_radius_z,
   output logic       rsp_valid,
   output logic       rsp_voxel_on,
   output logic [7:0] rsp_voxel_red,
   output logic [7:0] rsp_voxel_green,
   output logic [7:0] rsp_voxel_blue,
   output logic [7:0] rsp_voxel_alpha,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);
   logic [7:0] red_ff, green_ff, blue_ff, alpha_ff;
   cmd_type cmd;
   sts_type sts;
   logic out_on;
   logic [31:0] out_rgba;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff <= '0; green_ff <= '0; blue_ff <= '0; alpha_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RED:   red_ff   <= csr_data;
            CSR_GREEN: green_ff <= csr_data;
            CSR_BLUE:  blue_ff  <= csr_data;
            CSR_ALPHA: alpha_ff <= csr_data;
            default: ;
         endcase
      end
   end

   vsr_control u_ctl (
      .clock(clock), .reset(reset), .start(start), .kind(req_kind),
      .sts(sts), .cmd(cmd), .busy(busy)
   );

   vsr_datapath #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .kind(req_kind),
      .pos_x(req_pos_x), .pos_y(req_pos_y), .pos_z(req_pos_z),
      .end_x(req_end_x), .end_y(req_end_y), .end_z(req_end_z),
      .radius_x(req_radius_x), .radius_y(req_radius_y), .radius_z(req_radius_z),
      .color({alpha_ff, blue_ff, green_ff, red_ff}),
      .out_on(out_on), .out_rgba(out_rgba)
   );

   // read data registered on rd_issue is held through the result cycle
   assign rsp_valid       = cmd.rsp_fire;
   assign rsp_voxel_on    = out_on;
   assign rsp_voxel_red   = out_rgba[7:0];
   assign rsp_voxel_green = out_rgba[15:8];
   assign rsp_voxel_blue  = out_rgba[23:16];
   assign rsp_voxel_alpha = out_rgba[31:24];
endmodule

// ===== verif/voxel_checker.sv =====
// Watches the voxel rasterizer channels, predicts every result beat and compares it.
module voxel_checker import vsr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic [3:0] req_kind,
   input  logic [7:0] req_pos_x,
   input  logic [7:0] req_pos_y,
   input  logic [7:0] req_pos_z,
   input  logic [7:0] req_end_x,
   input  logic [7:0] req_end_y,
   input  logic [7:0] req_end_z,
   input  logic [6:0] req_radius_x,
   input  logic [6:0] req_radius_y,
   input  logic [6:0] req_radius_z,
   input  logic       rsp_valid,
   input  logic       rsp_voxel_on,
   input  logic [7:0] rsp_voxel_red,
   input  logic [7:0] rsp_voxel_green,
   input  logic [7:0] rsp_voxel_blue,
   input  logic [7:0] rsp_voxel_alpha,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data,
   output int         fail_cnt,
   output int         pending
);

   localparam int SIDE = 64;

   typedef struct packed {
      logic       on;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } voxel_type;

   voxel_type  grid_store [0:SIDE*SIDE*SIDE-1];
   voxel_type  readbacks [$];
   logic [7:0] paint [0:3];
   int         errors = 0;

   initial begin
      fail_cnt = 0;
      pending  = 0;
      for (int i = 0; i < SIDE*SIDE*SIDE; i++) grid_store[i] = '0;
      for (int i = 0; i < 4; i++) paint[i] = '0;
   end

   function automatic bit on_grid(int x, int y, int z);
      return x >= 0 && x < SIDE && y >= 0 && y < SIDE && z >= 0 && z < SIDE;
   endfunction

   function automatic longint sq(int d);
      return longint'(d) * longint'(d);
   endfunction

   task automatic paint_voxel(int x, int y, int z, bit fill);
      int idx;
      idx = (x * SIDE + y) * SIDE + z;
      if (fill) grid_store[idx] = {1'b1, paint[CSR_RED], paint[CSR_GREEN],
                                   paint[CSR_BLUE], paint[CSR_ALPHA]};
      else grid_store[idx].on = 1'b0;
   endtask

   task automatic rasterize(logic [3:0] kind, int px, int py, int pz, int ex, int ey,
                            int ez, longint rx, longint ry, longint rz);
      voxel_type seen;
      bit        fill;
      longint    wx, wy, wz, lim;
      seen = '0;
      fill = !kind[0];
      case (kind)
         KIND_PUT_VOXEL, KIND_CUT_VOXEL: begin
            if (on_grid(px, py, pz)) paint_voxel(px, py, pz, fill);
         end
         KIND_PUT_BOX, KIND_CUT_BOX: begin
            // clamp to the grid, end stays exclusive
            for (int i = (px < 0 ? 0 : px); i < (ex > SIDE ? SIDE : ex); i++)
               for (int j = (py < 0 ? 0 : py); j < (ey > SIDE ? SIDE : ey); j++)
                  for (int k = (pz < 0 ? 0 : pz); k < (ez > SIDE ? SIDE : ez); k++)
                     paint_voxel(i, j, k, fill);
         end
         KIND_PUT_ELLIP, KIND_CUT_ELLIP: begin
            wx  = ry * ry * rz * rz;
            wy  = rx * rx * rz * rz;
            wz  = rx * rx * ry * ry;
            lim = rx * rx * wx;
            if (lim != 0)
               for (int i = 0; i < SIDE; i++)
                  for (int j = 0; j < SIDE; j++)
                     for (int k = 0; k < SIDE; k++)
                        if (sq(i - px) * wx + sq(j - py) * wy + sq(k - pz) * wz < lim)
                           paint_voxel(i, j, k, fill);
         end
         KIND_PUT_SPHERE, KIND_CUT_SPHERE: begin
            lim = rx * rx;
            for (int i = 0; i < SIDE; i++)
               for (int j = 0; j < SIDE; j++)
                  for (int k = 0; k < SIDE; k++)
                     if (sq(i - px) + sq(j - py) + sq(k - pz) < lim)
                        paint_voxel(i, j, k, fill);
         end
         KIND_READ: begin
            if (on_grid(px, py, pz)) seen = grid_store[(px * SIDE + py) * SIDE + pz];
         end
         default: ;
      endcase
      readbacks.push_back(seen);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      voxel_type want;
      if (reset) begin
         for (int i = 0; i < 4; i++) paint[i] = '0;
      end else begin
         if (csr_valid && csr_ready) paint[csr_index] = csr_data;
         if (rsp_valid) begin
            if (readbacks.size() == 0) begin
               $display("%0t: unexpected result beat, expected none actual on=%0d",
                        $time, rsp_voxel_on);
               errors++;
            end else begin
               want = readbacks.pop_front();
               check_field("voxel_on", want.on, rsp_voxel_on);
               check_field("voxel_red", want.red, rsp_voxel_red);
               check_field("voxel_green", want.green, rsp_voxel_green);
               check_field("voxel_blue", want.blue, rsp_voxel_blue);
               check_field("voxel_alpha", want.alpha, rsp_voxel_alpha);
            end
         end
         if (start && !busy)
            rasterize(req_kind, $signed(req_pos_x), $signed(req_pos_y), $signed(req_pos_z),
                      $signed(req_end_x), $signed(req_end_y), $signed(req_end_z),
                      req_radius_x, req_radius_y, req_radius_z);
      end
      fail_cnt <= errors;
      pending  <= readbacks.size();
   end

endmodule

// ===== verif/tb_voxel_shape_rasterizer.sv =====
// Stimulus, watchdog and verdict for the voxel shape rasterizer.
module tb_voxel_shape_rasterizer;
   import vsr_pkg::*;

   localparam int WATCH_LIMIT = 800000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [3:0] req_kind = '0;
   logic [7:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [7:0] req_end_x = '0, req_end_y = '0, req_end_z = '0;
   logic [6:0] req_radius_x = '0, req_radius_y = '0, req_radius_z = '0;
   logic       rsp_valid, rsp_voxel_on;
   logic [7:0] rsp_voxel_red, rsp_voxel_green, rsp_voxel_blue, rsp_voxel_alpha;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_data = '0;
   int         fail_cnt, pending;
   int         quiet_cycles = 0;

   always #10 clock = ~clock;

   voxel_shape_rasterizer i_dut (.*);

   voxel_checker i_checker (.*);

   // count cycles without any beat on any channel
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send(logic [3:0] kind, logic [7:0] px, logic [7:0] py, logic [7:0] pz,
                       logic [7:0] ex, logic [7:0] ey, logic [7:0] ez,
                       logic [6:0] rx, logic [6:0] ry, logic [6:0] rz);
      req_kind     <= kind;
      req_pos_x    <= px;
      req_pos_y    <= py;
      req_pos_z    <= pz;
      req_end_x    <= ex;
      req_end_y    <= ey;
      req_end_z    <= ez;
      req_radius_x <= rx;
      req_radius_y <= ry;
      req_radius_z <= rz;
      start        <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // drop start, then hold until every result beat is back
   task automatic drain();
      hold_off(1);
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_colour(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
      logic [7:0] vals [4];
      vals = '{r, g, b, a};
      csr_valid <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= 2'(i);
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 8'($urandom_range(0, 7));
      if (r < 9) return 8'($urandom_range(0, 71) - 4);
      return 8'($urandom);
   endfunction

   task automatic random_command();
      logic [3:0] kind;
      logic [7:0] p [3];
      logic [7:0] e [3];
      logic [7:0] t;
      int         r;
      r = $urandom_range(0, 99);
      for (int i = 0; i < 3; i++) begin
         p[i] = pick_coord();
         e[i] = 8'($urandom);
      end
      if (r < 1) kind = 4'($urandom_range(KIND_PUT_ELLIP, KIND_CUT_SPHERE));
      else if (r < 36) kind = KIND_READ;
      else if (r < 66) kind = ($urandom_range(0, 2) != 0) ? KIND_PUT_VOXEL : KIND_CUT_VOXEL;
      else if (r < 86) begin
         kind = ($urandom_range(0, 2) != 0) ? KIND_PUT_BOX : KIND_CUT_BOX;
         for (int i = 0; i < 3; i++) e[i] = p[i] + 8'($urandom_range(0, 5));
      end else if (r < 93) begin
         // empty box: start at or past end on every axis
         kind = ($urandom_range(0, 1) != 0) ? KIND_PUT_BOX : KIND_CUT_BOX;
         for (int i = 0; i < 3; i++) begin
            p[i] = 8'($urandom);
            if ($signed(p[i]) < $signed(e[i])) begin
               t = p[i];
               p[i] = e[i];
               e[i] = t;
            end
         end
      end else kind = 4'($urandom_range(9, 15));
      send(kind, p[0], p[1], p[2], e[0], e[1], e[2],
           7'($urandom), 7'($urandom), 7'($urandom));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      write_colour(8'h11, 8'h22, 8'h33, 8'h44);
      send(KIND_PUT_VOXEL, 0, 0, 0, 8'h80, 8'h7f, 8'h80, 7'h7f, 0, 7'h7f);
      send(KIND_PUT_VOXEL, 63, 63, 63, 0, 0, 0, 0, 7'h7f, 0);
      send(KIND_PUT_VOXEL, 8'hff, 0, 0, 0, 0, 0, 0, 0, 0);
      send(KIND_PUT_VOXEL, 64, 5, 5, 0, 0, 0, 0, 0, 0);
      send(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send(KIND_READ, 63, 63, 63, 0, 0, 0, 0, 0, 0);
      send(KIND_READ, 8'h80, 8'h7f, 0, 0, 0, 0, 0, 0, 0);
      send(KIND_CUT_VOXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      hold_off($urandom_range(1, 11));
      send(KIND_PUT_BOX, 8'h80, 8'h80, 8'h80, 3, 3, 3, 0, 0, 0);
      send(KIND_PUT_BOX, 60, 60, 60, 8'h7f, 8'h7f, 8'h7f, 0, 0, 0);
      send(KIND_CUT_BOX, 1, 1, 1, 2, 2, 2, 0, 0, 0);
      send(KIND_PUT_BOX, 5, 5, 5, 5, 9, 9, 0, 0, 0);
      send(KIND_READ, 1, 1, 1, 0, 0, 0, 0, 0, 0);
      send(KIND_READ, 2, 2, 2, 0, 0, 0, 0, 0, 0);
      send(KIND_READ, 62, 62, 62, 0, 0, 0, 0, 0, 0);
      send(KIND_PUT_ELLIP, 32, 32, 32, 0, 0, 0, 3, 5, 7);
      send(KIND_READ, 32, 32, 38, 0, 0, 0, 0, 0, 0);
      send(KIND_PUT_ELLIP, 10, 10, 10, 0, 0, 0, 9, 0, 9);
      send(KIND_CUT_ELLIP, 32, 32, 32, 0, 0, 0, 2, 4, 127);
      send(KIND_PUT_SPHERE, 8'hfb, 70, 10, 0, 0, 0, 20, 0, 0);
      send(KIND_CUT_SPHERE, 20, 20, 20, 0, 0, 0, 0, 127, 127);
      send(KIND_CUT_SPHERE, 0, 0, 0, 0, 0, 0, 10, 1, 1);
      send(KIND_READ, 32, 32, 33, 0, 0, 0, 0, 0, 0);
      send(4'd9, 1, 1, 1, 0, 0, 0, 0, 0, 0);
      send(4'd15, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_colour(8'hff, 8'hff, 8'hff, 8'hff);
            1: write_colour(8'h00, 8'h00, 8'h00, 8'h00);
            default: write_colour(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         endcase
         for (int n = 0; n < 25; n++) begin
            random_command();
            if (phase < 3 && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 11));
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (fail_cnt == 0 && pending == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
